// ----- sv/twact_pkg.sv -----
// ============================================================================
// twact_pkg
// Shared types and constants of the time window activation tracker: stream
// field layout, operation and phase codes, event and queue control records.
// ============================================================================
`timescale 1ns / 1ps

package twact_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ENTRY_W = 5;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PH_W    = 2;

  localparam int unsigned IN_ENTRY_LSB = 0;
  localparam int unsigned IN_OWNER_LSB = IN_ENTRY_LSB + ENTRY_W;
  localparam int unsigned IN_START_LSB = IN_OWNER_LSB + OWNER_W;
  localparam int unsigned IN_END_LSB   = IN_START_LSB + TIME_W;
  localparam int unsigned IN_NOW_LSB   = IN_END_LSB + TIME_W;
  localparam int unsigned IN_USED_W    = IN_NOW_LSB + TIME_W;
  localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  localparam int unsigned OUT_USED_W = ENTRY_W + OWNER_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD          = 2'd0,
    OP_REMOVE       = 2'd1,
    OP_REMOVE_OWNER = 2'd2,
    OP_SET_TIME     = 2'd3
  } op_e;

  typedef enum logic [PH_W-1:0] {
    PH_FUTURE  = 2'd0,
    PH_PRESENT = 2'd1,
    PH_PAST    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [OWNER_W-1:0] owner;
    logic               active;
  } evt_t;

  typedef struct packed {
    evt_t evt;
    logic last;
  } out_t;

  typedef struct packed {
    logic push;
    logic flush;
  } evq_ctrl_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } evq_stat_t;

endpackage

// ----- sv/twact_ram.sv -----
// ============================================================================
// twact_ram
// Window table storage: one write port, one read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps

module twact_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 74,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/twact_evq.sv -----
// ============================================================================
// twact_evq
// Event output stage: one pending event plus the output register. A pending
// event moves out when the next one arrives, or with last set on flush.
// ============================================================================
`timescale 1ns / 1ps

module twact_evq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  twact_pkg::evq_ctrl_t  ctrl_i,
  input  twact_pkg::evt_t       evt_i,
  output twact_pkg::evq_stat_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output twact_pkg::out_t       out_o
);

  import twact_pkg::*;

  logic   pend_v_q, pend_v_d;
  evt_t   pend_q, pend_d;
  logic   out_v_q, out_v_d;
  out_t   out_q, out_d;
  logic   out_free;

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    if (ctrl_i.push) begin
      if (pend_v_q) begin
        out_d   = '{evt: pend_q, last: 1'b0};
        out_v_d = 1'b1;
      end
      pend_d   = evt_i;
      pend_v_d = 1'b1;
    end else if (ctrl_i.flush && pend_v_q && out_free) begin
      out_d    = '{evt: pend_q, last: 1'b1};
      out_v_d  = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign stat_o.ready = !pend_v_q || out_free;
  assign stat_o.busy  = pend_v_q;
  assign out_valid_o  = out_v_q;
  assign out_o        = out_q;

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> stat_o.ready)
    else $error("event pushed while stage full");

  a_push_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.flush))
    else $error("push and flush together");

  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_v_q) |-> out_v_q && out_q.last)
    else $error("pending event dropped without last");

endmodule

// ----- sv/time_window_activation_tracker.sv -----
// ============================================================================
// time_window_activation_tracker
// Table of timed windows held in a synchronous RAM. Add, remove, owner
// removal and time updates reclassify windows and emit activity events.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tuser: op; tdata: entry_id, owner_id, start_time, end_time,
//                now_time
// m_axis    out  tdata: event_entry, event_owner; tuser: became_active;
//                tlast: last
// Owner removal and a time change walk the whole table through the RAM read
// port; a set time equal to the stored time completes without a table walk.
// Reset clears the valid bits and the current time; no clearing pass is run.
// A stalled m_axis holds the table walk; s_axis is taken again once the last
// event of the transaction sits in the output register.
// ============================================================================
`timescale 1ns / 1ps

module time_window_activation_tracker #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_id, owner_id, start_time, end_time, now_time, zero fill
  input  logic [twact_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [twact_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // event_entry, event_owner, zero fill
  output logic [twact_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // became_active
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  import twact_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;
  localparam int unsigned WORD_W = 2 * TIME_BITS + OWNER_BITS + PH_W;
  localparam int unsigned OWN_LSB = PH_W;
  localparam int unsigned END_LSB = PH_W + OWNER_BITS;
  localparam int unsigned STA_LSB = END_LSB + TIME_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ONE   = 5'b00010,
    S_TWO   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  function automatic phase_e classify(input logic signed [TIME_BITS-1:0] s,
                                      input logic signed [TIME_BITS-1:0] e,
                                      input logic signed [TIME_BITS-1:0] now);
    phase_e ph;
    if (s > now) begin
      ph = PH_FUTURE;
    end else if (e < now) begin
      ph = PH_PAST;
    end else begin
      ph = PH_PRESENT;
    end
    return ph;
  endfunction

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]               proc_idx_q, proc_idx_d;
  logic                           dv_q, dv_d;
  logic [ENTRIES-1:0]             valid_q, valid_d;
  logic signed [TIME_BITS-1:0]    cur_q, cur_d;

  op_e                            op_q;
  logic [ENTRY_W-1:0]             slot_q;
  logic [OWNER_BITS-1:0]          owner_q;
  logic signed [TIME_BITS-1:0]    start_q, end_q;

  logic                           in_accept;
  op_e                            in_op;
  logic [ENTRY_W-1:0]             in_entry;
  logic [OWNER_W-1:0]             in_owner;
  logic signed [TIME_W-1:0]       in_start, in_end, in_now;
  logic signed [TIME_BITS-1:0]    in_now_t;

  logic                           ram_re, ram_we;
  logic [IDX_W-1:0]               ram_raddr, ram_waddr;
  logic [WORD_W-1:0]              ram_wdata, ram_rdata;

  phase_e                         rd_ph;
  logic [OWNER_BITS-1:0]          rd_owner;
  logic signed [TIME_BITS-1:0]    rd_start, rd_end;

  logic [IDX_W-1:0]               slot_addr;
  logic                           slot_ok, old_valid, old_present, same_owner;
  logic                           need_deact, need_act;
  phase_e                         new_ph, scan_ph;
  logic                           scan_hit, scan_need, scan_act;

  evq_ctrl_t                      evq_ctrl;
  evq_stat_t                      evq_stat;
  evt_t                           push_evt;
  out_t                           out_item;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_op     = op_e'(s_axis_tuser);
  assign in_entry  = s_axis_tdata[IN_ENTRY_LSB +: ENTRY_W];
  assign in_owner  = s_axis_tdata[IN_OWNER_LSB +: OWNER_W];
  assign in_start  = s_axis_tdata[IN_START_LSB +: TIME_W];
  assign in_end    = s_axis_tdata[IN_END_LSB +: TIME_W];
  assign in_now    = s_axis_tdata[IN_NOW_LSB +: TIME_W];
  assign in_now_t  = TIME_BITS'(in_now);

  assign rd_ph    = phase_e'(ram_rdata[PH_W-1:0]);
  assign rd_owner = ram_rdata[OWN_LSB +: OWNER_BITS];
  assign rd_end   = ram_rdata[END_LSB +: TIME_BITS];
  assign rd_start = ram_rdata[STA_LSB +: TIME_BITS];

  assign slot_addr   = IDX_W'(slot_q);
  assign slot_ok     = CMP_W'(slot_q) < CMP_W'(ENTRIES);
  assign old_valid   = valid_q[slot_addr];
  assign old_present = old_valid && (rd_ph == PH_PRESENT);
  assign same_owner  = rd_owner == owner_q;
  assign new_ph      = classify(start_q, end_q, cur_q);
  assign need_deact  = old_present && ((new_ph != PH_PRESENT) || !same_owner);
  assign need_act    = (new_ph == PH_PRESENT) && (!old_present || !same_owner);

  assign scan_ph  = classify(rd_start, rd_end, cur_q);
  assign scan_act = (op_q == OP_SET_TIME) && (scan_ph == PH_PRESENT);

  always_comb begin
    scan_hit  = 1'b0;
    scan_need = 1'b0;
    case (op_q)
      OP_REMOVE_OWNER: begin
        scan_hit  = dv_q && valid_q[proc_idx_q] && (rd_owner == owner_q);
        scan_need = scan_hit && (rd_ph == PH_PRESENT);
      end
      OP_SET_TIME: begin
        scan_hit  = dv_q && valid_q[proc_idx_q];
        scan_need = scan_hit && ((scan_ph == PH_PRESENT) != (rd_ph == PH_PRESENT));
      end
      default: begin
        scan_hit  = 1'b0;
        scan_need = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    proc_idx_d = proc_idx_q;
    dv_d       = dv_q;
    valid_d    = valid_q;
    cur_d      = cur_q;
    ram_re     = 1'b0;
    ram_raddr  = IDX_W'(in_entry);
    ram_we     = 1'b0;
    ram_waddr  = slot_addr;
    ram_wdata  = {start_q, end_q, owner_q, new_ph};
    evq_ctrl   = '0;
    push_evt   = '{entry: slot_q, owner: OWNER_W'(rd_owner), active: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_ADD, OP_REMOVE: begin
              ram_re  = 1'b1;
              state_d = S_ONE;
            end
            OP_REMOVE_OWNER: begin
              rd_idx_d = '0;
              dv_d     = 1'b0;
              state_d  = S_SCAN;
            end
            OP_SET_TIME: begin
              if (in_now_t != cur_q) begin
                cur_d    = in_now_t;
                rd_idx_d = '0;
                dv_d     = 1'b0;
                state_d  = S_SCAN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ONE: begin
        if (!slot_ok) begin
          state_d = S_FLUSH;
        end else if (op_q == OP_REMOVE) begin
          if (!old_valid) begin
            state_d = S_FLUSH;
          end else if (!old_present || evq_stat.ready) begin
            evq_ctrl.push       = old_present;
            valid_d[slot_addr]  = 1'b0;
            state_d             = S_FLUSH;
          end
        end else if (!need_deact || evq_stat.ready) begin
          evq_ctrl.push = need_deact;
          state_d       = S_TWO;
        end
      end

      S_TWO: begin
        push_evt = '{entry: slot_q, owner: OWNER_W'(owner_q), active: 1'b1};
        if (!need_act || evq_stat.ready) begin
          evq_ctrl.push      = need_act;
          ram_we             = 1'b1;
          valid_d[slot_addr] = 1'b1;
          state_d            = S_FLUSH;
        end
      end

      S_SCAN: begin
        push_evt  = '{entry: ENTRY_W'(proc_idx_q), owner: OWNER_W'(rd_owner),
                      active: scan_act};
        ram_waddr = proc_idx_q;
        ram_wdata = {rd_start, rd_end, rd_owner, scan_ph};
        ram_raddr = rd_idx_q[IDX_W-1:0];
        if (!scan_need || evq_stat.ready) begin
          evq_ctrl.push = scan_need;
          if (scan_hit) begin
            if (op_q == OP_SET_TIME) begin
              ram_we = 1'b1;
            end else begin
              valid_d[proc_idx_q] = 1'b0;
            end
          end
          if (rd_idx_q < CNT_W'(ENTRIES)) begin
            ram_re     = 1'b1;
            proc_idx_d = rd_idx_q[IDX_W-1:0];
            dv_d       = 1'b1;
            rd_idx_d   = rd_idx_q + CNT_W'(1);
          end else begin
            dv_d    = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        evq_ctrl.flush = 1'b1;
        if (!evq_stat.busy) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_idx_q   <= '0;
      proc_idx_q <= '0;
      dv_q       <= 1'b0;
      valid_q    <= '0;
      cur_q      <= '0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      proc_idx_q <= proc_idx_d;
      dv_q       <= dv_d;
      valid_q    <= valid_d;
      cur_q      <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= in_op;
      slot_q  <= in_entry;
      owner_q <= OWNER_BITS'(in_owner);
      start_q <= TIME_BITS'(in_start);
      end_q   <= TIME_BITS'(in_end);
    end
  end

  assign s_axis_tready = state_q == S_IDLE;

  twact_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  twact_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (evq_ctrl),
    .evt_i       (push_evt),
    .stat_o      (evq_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_item)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_item.evt.owner, out_item.evt.entry};
  assign m_axis_tuser = out_item.evt.active;
  assign m_axis_tlast = out_item.last;

  a_ram_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write to the same entry");

  a_ram_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_TWO) || (state_q == S_SCAN))
    else $error("RAM write outside update states");

  a_scan_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (state_d == S_FLUSH) |-> rd_idx_q == CNT_W'(ENTRIES) && !dv_d)
    else $error("table walk left early");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && (in_op == OP_SET_TIME)) |=> $stable(cur_q))
    else $error("current time changed without a set time transaction");

endmodule

// ----- bench/time_window_activation_tracker_tb.sv -----
// ============================================================================
// time_window_activation_tracker_tb
// Self-checking bench for the timed window activation tracker. A directed
// table covers reset state, range extremes, replace, removal and time update
// cases, then a long random run of window adds, removals, owner sweeps and
// time moves. Each s_axis transaction updates a local model of the window
// table and queues the activity events it should produce. Every m_axis
// transaction is checked field by field against the oldest queued event.
// ============================================================================
`timescale 1ns / 1ps

module time_window_activation_tracker_tb;

  import twact_pkg::*;

  localparam int unsigned SLOTS      = 32;
  localparam int unsigned RAND_ITEMS = 460;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 2 * SLOTS + 10;

  localparam logic signed [TIME_W-1:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0] T_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    op_e                       op;
    logic [ENTRY_W-1:0]        entry;
    logic [OWNER_W-1:0]        owner;
    logic signed [TIME_W-1:0]  lo;
    logic signed [TIME_W-1:0]  hi;
    logic signed [TIME_W-1:0]  now;
    bit                        typed;
    bit                        t_has;
    logic [ENTRY_W-1:0]        t_entry;
    logic [OWNER_W-1:0]        t_owner;
    bit                        t_act;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // window table model
  bit                       slot_used [SLOTS];
  logic signed [TIME_W-1:0] win_lo    [SLOTS];
  logic signed [TIME_W-1:0] win_hi    [SLOTS];
  logic [OWNER_W-1:0]       win_owner [SLOTS];
  phase_e                   win_phase [SLOTS];
  logic signed [TIME_W-1:0] clock_now;

  out_t       activity_q [$];
  stim_row_t  dir_q [$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned op_count [4];
  int unsigned events_seen;
  int unsigned activations_seen;
  bit          calm;

  time_window_activation_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic phase_e phase_of(input logic signed [TIME_W-1:0] lo,
                                      input logic signed [TIME_W-1:0] hi,
                                      input logic signed [TIME_W-1:0] now);
    if (lo > now) return PH_FUTURE;
    if (hi < now) return PH_PAST;
    return PH_PRESENT;
  endfunction

  function automatic out_t make_event(input logic [ENTRY_W-1:0] slot,
                                      input logic [OWNER_W-1:0] who,
                                      input bit act);
    out_t ev;
    ev = '0;
    ev.evt.entry  = slot;
    ev.evt.owner  = who;
    ev.evt.active = act;
    return ev;
  endfunction

  // advance the window table by one transaction and queue its events
  task automatic track_window_op(input op_e op, input logic [ENTRY_W-1:0] slot,
                                 input logic [OWNER_W-1:0] who,
                                 input logic signed [TIME_W-1:0] lo,
                                 input logic signed [TIME_W-1:0] hi,
                                 input logic signed [TIME_W-1:0] now,
                                 input bit keep);
    out_t   burst [$];
    phase_e ph;
    bit     was_on;
    bit     same_owner;
    case (op)
      OP_ADD: begin
        ph = phase_of(lo, hi, clock_now);
        was_on = slot_used[slot] && win_phase[slot] == PH_PRESENT;
        same_owner = win_owner[slot] == who;
        if (was_on && (ph != PH_PRESENT || !same_owner))
          burst.insert(burst.size(), make_event(slot, win_owner[slot], 1'b0));
        if (ph == PH_PRESENT && (!was_on || !same_owner))
          burst.insert(burst.size(), make_event(slot, who, 1'b1));
        slot_used[slot] = 1'b1;
        win_lo[slot]    = lo;
        win_hi[slot]    = hi;
        win_owner[slot] = who;
        win_phase[slot] = ph;
      end
      OP_REMOVE: begin
        if (slot_used[slot]) begin
          if (win_phase[slot] == PH_PRESENT)
            burst.insert(burst.size(), make_event(slot, win_owner[slot], 1'b0));
          slot_used[slot] = 1'b0;
        end
      end
      OP_REMOVE_OWNER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && win_owner[i] == who) begin
            if (win_phase[i] == PH_PRESENT)
              burst.insert(burst.size(), make_event(ENTRY_W'(i), win_owner[i], 1'b0));
            slot_used[i] = 1'b0;
          end
        end
      end
      default: begin
        if (now != clock_now) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              ph = phase_of(win_lo[i], win_hi[i], now);
              if (ph == PH_PRESENT && win_phase[i] != PH_PRESENT)
                burst.insert(burst.size(), make_event(ENTRY_W'(i), win_owner[i], 1'b1));
              else if (ph != PH_PRESENT && win_phase[i] == PH_PRESENT)
                burst.insert(burst.size(), make_event(ENTRY_W'(i), win_owner[i], 1'b0));
              win_phase[i] = ph;
            end
          end
          clock_now = now;
        end
      end
    endcase
    if (burst.size() > 0)
      burst[burst.size()-1].last = 1'b1;
    if (keep)
      foreach (burst[k]) activity_q.insert(activity_q.size(), burst[k]);
  endtask

  task automatic drive_item(input op_e op, input logic [ENTRY_W-1:0] slot,
                            input logic [OWNER_W-1:0] who,
                            input logic signed [TIME_W-1:0] lo,
                            input logic signed [TIME_W-1:0] hi,
                            input logic signed [TIME_W-1:0] now,
                            input bit keep);
    logic [IN_DATA_W-1:0] word;
    int unsigned          gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 8) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[IN_ENTRY_LSB +: ENTRY_W] = slot;
    word[IN_OWNER_LSB +: OWNER_W] = who;
    word[IN_START_LSB +: TIME_W]  = lo;
    word[IN_END_LSB   +: TIME_W]  = hi;
    word[IN_NOW_LSB   +: TIME_W]  = now;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    op_count[op]++;
    track_window_op(op, slot, who, lo, hi, now, keep);
  endtask

  task automatic wait_drained();
    while (activity_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic row(input op_e op, input logic [ENTRY_W-1:0] slot,
                     input logic [OWNER_W-1:0] who,
                     input logic signed [TIME_W-1:0] lo,
                     input logic signed [TIME_W-1:0] hi,
                     input logic signed [TIME_W-1:0] now,
                     input bit typed, input bit t_has,
                     input logic [ENTRY_W-1:0] t_entry,
                     input logic [OWNER_W-1:0] t_owner, input bit t_act);
    stim_row_t r;
    r.op = op; r.entry = slot; r.owner = who; r.lo = lo; r.hi = hi; r.now = now;
    r.typed = typed; r.t_has = t_has;
    r.t_entry = t_entry; r.t_owner = t_owner; r.t_act = t_act;
    dir_q.insert(dir_q.size(), r);
  endtask

  function automatic logic signed [TIME_W-1:0] pick_time();
    int v;
    if ($urandom_range(99) < 15) return $urandom;
    v = $urandom_range(0, 160);
    return v - 80;
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    if ($urandom_range(99) < 80) return OWNER_W'($urandom_range(0, 7));
    return OWNER_W'($urandom_range(0, 255));
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin : event_check
    out_t               want;
    logic [ENTRY_W-1:0] got_entry;
    logic [OWNER_W-1:0] got_owner;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_entry = m_axis_tdata[0 +: ENTRY_W];
      got_owner = m_axis_tdata[ENTRY_W +: OWNER_W];
      events_seen++;
      if (m_axis_tuser[0]) activations_seen++;
      if (activity_q.size() == 0) begin
        $display("%0t: unexpected event entry %0d owner %0d active %0b last %0b",
                 $time, got_entry, got_owner, m_axis_tuser[0], m_axis_tlast);
        errors++;
      end else begin
        want = activity_q.pop_front();
        if (got_entry !== want.evt.entry) begin
          $display("%0t: event_entry expected %0d got %0d", $time, want.evt.entry,
                   got_entry);
          errors++;
        end
        if (got_owner !== want.evt.owner) begin
          $display("%0t: event_owner expected %0d got %0d", $time, want.evt.owner,
                   got_owner);
          errors++;
        end
        if (m_axis_tuser[0] !== want.evt.active) begin
          $display("%0t: became_active expected %0b got %0b", $time, want.evt.active,
                   m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t                r;
    op_e                      op;
    logic [ENTRY_W-1:0]       slot;
    logic [OWNER_W-1:0]       who;
    logic signed [TIME_W-1:0] lo;
    logic signed [TIME_W-1:0] hi;
    logic signed [TIME_W-1:0] now;
    int unsigned              pick;

    errors = 0;
    idle_cycles = 0;
    events_seen = 0;
    activations_seen = 0;
    calm = 1'b0;
    foreach (op_count[k]) op_count[k] = 0;
    foreach (slot_used[k]) begin
      slot_used[k] = 1'b0;
      win_lo[k]    = '0;
      win_hi[k]    = '0;
      win_owner[k] = '0;
      win_phase[k] = PH_FUTURE;
    end
    clock_now = '0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ADD;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: op, slot, owner, start, end, now, typed, has, entry, owner, act
    row(OP_ADD,          0, 8'h11, -10,   10,    0,     1, 1, 0,  8'h11, 1);
    row(OP_REMOVE,       5, 8'h00, 0,     0,     0,     1, 0, 0,  8'h00, 0);
    row(OP_SET_TIME,     0, 8'h00, 0,     0,     0,     1, 0, 0,  8'h00, 0);
    row(OP_ADD,          31, 8'hFF, T_MIN, T_MAX, 0,    1, 1, 31, 8'hFF, 1);
    row(OP_ADD,          1, 8'h22, 100,   200,   0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          2, 8'h22, -200,  -100,  0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          3, 8'h33, 50,    -50,   0,     0, 0, 0,  8'h00, 0);
    row(OP_SET_TIME,     0, 8'h00, 0,     0,     150,   0, 0, 0,  8'h00, 0);
    row(OP_ADD,          1, 8'h22, 100,   300,   0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          1, 8'h44, 100,   300,   0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          1, 8'h44, 500,   600,   0,     0, 0, 0,  8'h00, 0);
    row(OP_REMOVE,       31, 8'h00, 0,    0,     0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          31, 8'hFF, T_MIN, T_MAX, 0,    0, 0, 0,  8'h00, 0);
    row(OP_ADD,          4, 8'h22, 0,     1000,  0,     0, 0, 0,  8'h00, 0);
    row(OP_ADD,          5, 8'h22, 0,     1000,  0,     0, 0, 0,  8'h00, 0);
    row(OP_REMOVE_OWNER, 0, 8'h22, 0,     0,     0,     0, 0, 0,  8'h00, 0);
    row(OP_SET_TIME,     0, 8'h00, 0,     0,     T_MIN, 0, 0, 0,  8'h00, 0);
    row(OP_ADD,          6, 8'h01, T_MIN, T_MIN, 0,     0, 0, 0,  8'h00, 0);
    row(OP_SET_TIME,     0, 8'h00, 0,     0,     T_MAX, 0, 0, 0,  8'h00, 0);
    row(OP_ADD,          7, 8'h00, T_MAX, T_MAX, 0,     0, 0, 0,  8'h00, 0);
    row(OP_REMOVE_OWNER, 0, 8'hFF, 0,     0,     0,     0, 0, 0,  8'h00, 0);
    row(OP_REMOVE_OWNER, 0, 8'h00, 0,     0,     0,     0, 0, 0,  8'h00, 0);
    row(OP_SET_TIME,     0, 8'h00, 0,     0,     0,     0, 0, 0,  8'h00, 0);

    foreach (dir_q[k]) begin
      r = dir_q[k];
      drive_item(r.op, r.entry, r.owner, r.lo, r.hi, r.now, !r.typed);
      if (r.typed && r.t_has) begin
        activity_q.insert(activity_q.size(), make_event(r.t_entry, r.t_owner, r.t_act));
        activity_q[activity_q.size()-1].last = 1'b1;
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100 || n == 400) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      calm = (n >= 200 && n < 320);
      slot = ENTRY_W'($urandom);
      who  = OWNER_W'($urandom);
      lo   = $urandom;
      hi   = $urandom;
      now  = $urandom;
      pick = $urandom_range(99);
      if (pick < 40) begin
        op = OP_ADD;
        who = pick_owner();
        lo = pick_time();
        hi = ($urandom_range(99) < 75) ? lo + $urandom_range(0, 60) : pick_time();
      end else if (pick < 55) begin
        op = OP_REMOVE;
      end else if (pick < 65) begin
        op = OP_REMOVE_OWNER;
        who = pick_owner();
      end else begin
        op = OP_SET_TIME;
        now = ($urandom_range(99) < 10) ? clock_now : pick_time();
      end
      drive_item(op, slot, who, lo, hi, now, 1'b1);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d adds, %0d removes, %0d owner sweeps, %0d time moves;",
             op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_REMOVE_OWNER],
             op_count[OP_SET_TIME]);
    $display("checked %0d activity events, %0d of them activations.", events_seen,
             activations_seen);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
